// ----- rtl/fpsp_pkg.sv -----
// fpsp_pkg: shared types and codes for the framed pdu stream parser
// no dependencies; imported by framed_pdu_stream_parser_core
`default_nettype none

package fpsp_pkg;

  // field types
  typedef logic [7:0]  byte_t;
  typedef logic [1:0]  event_t;
  typedef logic [3:0]  nibble_t;
  typedef logic [15:0] count_t;
  typedef logic [1:0]  ftype_t;
  typedef logic [11:0] fsize_t;
  typedef logic [2:0]  status_t;

  // event codes
  localparam event_t EV_NONE   = 2'd0;
  localparam event_t EV_HEADER = 2'd1;
  localparam event_t EV_FRAME  = 2'd2;
  localparam event_t EV_DATA   = 2'd3;

  // buffer status codes
  localparam status_t ST_BUSY  = 3'd0;
  localparam status_t ST_OK    = 3'd1;
  localparam status_t ST_SHORT = 3'd2;
  localparam status_t ST_EARLY = 3'd3;
  localparam status_t ST_NOFIN = 3'd4;

  // frame header bit position and frame count limit
  localparam int unsigned FinalBit = 7;
  localparam count_t      CountMax = 16'hFFFF;

  // one result transaction
  typedef struct packed {
    event_t  event_res;
    nibble_t version;
    nibble_t opcode;
    byte_t   header_flags;
    count_t  payload_count;
    ftype_t  frame_type;
    fsize_t  frame_size;
    logic    frame_final;
    byte_t   data_byte;
    status_t status;
    count_t  frame_count;
  } result_t;

endpackage : fpsp_pkg

`default_nettype wire

// ----- rtl/framed_pdu_stream_parser_core.sv -----
// framed_pdu_stream_parser_core: byte-serial parser for a framed pdu buffer
// depends on fpsp_pkg (types, event and status codes)
//
// usage:
// - input channel (in_valid_i / in_stall_o) carries one buffer byte per
//   transaction, with last_i marking the final byte of the buffer; the next
//   byte after a last byte opens a new buffer
// - output channel (out_valid_o / out_stall_i) returns exactly one result
//   transaction per input byte: an event (header, frame header, data byte or
//   none), the decoded fields of that event, the buffer status and the
//   saturating count of frames completed so far in the buffer
// - the result of a byte is registered: it is on the output ports right
//   after the edge that accepts the byte
// - throughput is one byte per cycle while the output is not stalled; the
//   parse step is a small phase update and a 12-bit count decrement between
//   the state registers and the result register
// - while the receiver stalls a waiting result, the result register holds
//   and in_stall_o is raised; a new byte is taken in the same cycle the held
//   result leaves
// - reset puts the parser at the first header byte and clears out_valid_o;
//   the result payload itself is not reset
`default_nettype none

module framed_pdu_stream_parser_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire fpsp_pkg::byte_t   byte_in_i,
  input  wire logic              last_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output fpsp_pkg::event_t       event_res_o,
  output fpsp_pkg::nibble_t      version_o,
  output fpsp_pkg::nibble_t      opcode_o,
  output fpsp_pkg::byte_t        header_flags_o,
  output fpsp_pkg::count_t       payload_count_o,
  output fpsp_pkg::ftype_t       frame_type_o,
  output fpsp_pkg::fsize_t       frame_size_o,
  output logic                   frame_final_o,
  output fpsp_pkg::byte_t        data_byte_o,
  output fpsp_pkg::status_t      status_o,
  output fpsp_pkg::count_t       frame_count_o
);
  import fpsp_pkg::*;

  // parser phases
  localparam logic [2:0] PH_H0   = 3'd0;  // version / opcode byte
  localparam logic [2:0] PH_H1   = 3'd1;  // flags byte
  localparam logic [2:0] PH_H2   = 3'd2;  // payload count high byte
  localparam logic [2:0] PH_H3   = 3'd3;  // payload count low byte
  localparam logic [2:0] PH_F0   = 3'd4;  // first frame header byte
  localparam logic [2:0] PH_F1   = 3'd5;  // second frame header byte
  localparam logic [2:0] PH_DATA = 3'd6;  // frame data bytes
  localparam logic [2:0] PH_SKIP = 3'd7;  // drop bytes after an early final

  logic [2:0]  phase_q, phase_d;
  fsize_t      remaining_q, remaining_d;
  logic        final_q, final_d;
  logic [23:0] latch_q, latch_d;
  count_t      frames_q, frames_d;

  result_t     res_q, res_d;
  logic        out_valid_q, out_valid_d;

  logic        in_accept;
  logic        frame_done;
  fsize_t      new_size;

  // the result register frees up in the cycle its transaction leaves
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign new_size = {latch_q[3:0], byte_in_i};

  // parse step for one byte
  always_comb begin
    phase_d     = phase_q;
    remaining_d = remaining_q;
    final_d     = final_q;
    latch_d     = latch_q;
    frames_d    = frames_q;
    frame_done  = 1'b0;
    res_d       = '0;
    res_d.status = ST_BUSY;

    unique case (phase_q)
      PH_H0: begin
        frames_d = '0;
        latch_d  = {byte_in_i, 16'h0000};
        phase_d  = PH_H1;
        if (last_i) res_d.status = ST_SHORT;
      end
      PH_H1: begin
        latch_d = {latch_q[23:16], byte_in_i, 8'h00};
        phase_d = PH_H2;
        if (last_i) res_d.status = ST_SHORT;
      end
      PH_H2: begin
        latch_d = {latch_q[23:8], byte_in_i};
        phase_d = PH_H3;
        if (last_i) res_d.status = ST_SHORT;
      end
      PH_H3: begin
        res_d.event_res     = EV_HEADER;
        res_d.version       = latch_q[23:20];
        res_d.opcode        = latch_q[19:16];
        res_d.header_flags  = latch_q[15:8];
        res_d.payload_count = {latch_q[7:0], byte_in_i};
        phase_d = PH_F0;
        if (last_i) res_d.status = ST_OK;
      end
      PH_F0: begin
        latch_d = {16'h0000, byte_in_i};
        final_d = byte_in_i[FinalBit];
        phase_d = PH_F1;
        if (last_i) res_d.status = ST_SHORT;
      end
      PH_F1: begin
        remaining_d       = new_size;
        res_d.event_res   = EV_FRAME;
        res_d.frame_type  = latch_q[5:4];
        res_d.frame_size  = new_size;
        res_d.frame_final = final_q;
        if (new_size == '0) begin
          frame_done = 1'b1;
        end else begin
          phase_d = PH_DATA;
          if (last_i) res_d.status = ST_SHORT;
        end
      end
      PH_DATA: begin
        res_d.event_res = EV_DATA;
        res_d.data_byte = byte_in_i;
        if (remaining_q <= fsize_t'(1)) begin
          remaining_d = '0;
          frame_done  = 1'b1;
        end else begin
          remaining_d = remaining_q - fsize_t'(1);
          if (last_i) res_d.status = ST_SHORT;
        end
      end
      PH_SKIP: begin
        res_d.status = ST_EARLY;
      end
    endcase

    // frame completion: count it and decide how the buffer stands
    if (frame_done) begin
      if (frames_q != CountMax) frames_d = frames_q + count_t'(1);
      if (final_q) begin
        res_d.status = last_i ? ST_OK : ST_EARLY;
        phase_d      = PH_SKIP;
      end else begin
        res_d.status = last_i ? ST_NOFIN : ST_BUSY;
        phase_d      = PH_F0;
      end
    end

    res_d.frame_count = frames_d;

    // end of buffer: next byte opens a new header
    if (last_i) begin
      phase_d     = PH_H0;
      remaining_d = '0;
      final_d     = 1'b0;
      latch_d     = '0;
    end
  end

  always_comb begin
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // parser state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_H0;
      remaining_q <= '0;
      final_q     <= 1'b0;
      latch_q     <= '0;
      frames_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        phase_q     <= phase_d;
        remaining_q <= remaining_d;
        final_q     <= final_d;
        latch_q     <= latch_d;
        frames_q    <= frames_d;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_res_o     = res_q.event_res;
  assign version_o       = res_q.version;
  assign opcode_o        = res_q.opcode;
  assign header_flags_o  = res_q.header_flags;
  assign payload_count_o = res_q.payload_count;
  assign frame_type_o    = res_q.frame_type;
  assign frame_size_o    = res_q.frame_size;
  assign frame_final_o   = res_q.frame_final;
  assign data_byte_o     = res_q.data_byte;
  assign status_o        = res_q.status;
  assign frame_count_o   = res_q.frame_count;

  // every accepted byte produces a result on the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted byte produced no result");

  // skipping only follows a completed frame, so no data is still due
  a_skip_no_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> (remaining_q == '0))
    else $error("skip phase with frame data outstanding");

  // a header event never carries a frame error status
  a_header_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_HEADER) |-> (status_o == ST_BUSY || status_o == ST_OK))
    else $error("header event with error status");

  // a byte that does not end the buffer leaves the parser outside the header start
  a_mid_buffer_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !last_i) |=> (phase_q != PH_H0))
    else $error("parser restarted inside a buffer");

endmodule : framed_pdu_stream_parser_core

`default_nettype wire
